// ===== src/sfe_pkg.sv =====
`default_nettype none

package sfe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int TAP_W      = 18;
  localparam int HIST_W     = 32;
  localparam int PROD_W     = TAP_W + HIST_W;
  localparam int PRE_W      = 2 * SAMPLE_W + 1;
  localparam int PRE_SHIFT  = 15;
  localparam int ACC_SHIFT  = 31;
  localparam int POST_SHIFT = 8;
  localparam int Y_W        = PROD_W - POST_SHIFT;
  localparam int COEF_IDX_W = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POST_GAIN   = 2'd2;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  localparam logic MODE_BYPASS = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  localparam logic [GAIN_W-1:0] PRE_GAIN_RST  = 16'd32768;
  localparam logic [GAIN_W-1:0] POST_GAIN_RST = 16'd256;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRE_L,
    OP_PRE_R,
    OP_TAP_L,
    OP_TAP_R,
    OP_QUANT,
    OP_POST_L,
    OP_POST_R
  } mac_op_e;

  typedef struct packed {
    mac_op_e op;
    logic    acc_clr;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       clipped;
  } mac_res_t;

endpackage

`default_nettype wire

// ===== src/sfe_store.sv =====
`default_nettype none

module sfe_store #(
  parameter int TAP_COUNT = 128,
  parameter int AW        = 7
) (
  input  wire logic                              clk_i,
  input  wire logic                              tap_we_i,
  input  wire logic [AW-1:0]                     tap_waddr_i,
  input  wire logic signed [sfe_pkg::TAP_W-1:0]  tap_wdata_i,
  input  wire logic                              hist_we_i,
  input  wire logic [AW-1:0]                     hist_waddr_i,
  input  wire logic [2*sfe_pkg::HIST_W-1:0]      hist_wdata_i,
  input  wire logic                              rd_en_i,
  input  wire logic [AW-1:0]                     tap_raddr_i,
  input  wire logic [AW-1:0]                     hist_raddr_i,
  output logic signed [sfe_pkg::TAP_W-1:0]       tap_rdata_o,
  output logic [2*sfe_pkg::HIST_W-1:0]           hist_rdata_o
);
  import sfe_pkg::*;

  // history word: right channel in the upper half, left in the lower
  logic signed [TAP_W-1:0]    tap_mem  [TAP_COUNT];
  logic [2*HIST_W-1:0]        hist_mem [TAP_COUNT];

  always_ff @(posedge clk_i) begin
    if (tap_we_i) begin
      tap_mem[tap_waddr_i] <= tap_wdata_i;
    end
    if (rd_en_i) begin
      tap_rdata_o <= tap_mem[tap_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we_i) begin
      hist_mem[hist_waddr_i] <= hist_wdata_i;
    end
    if (rd_en_i) begin
      hist_rdata_o <= hist_mem[hist_raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/sfe_mac.sv =====
`default_nettype none

module sfe_mac #(
  parameter int TAP_COUNT = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire sfe_pkg::mac_ctl_t                    ctl_i,
  input  wire logic                                 filter_mode_i,
  input  wire logic [sfe_pkg::GAIN_W-1:0]           pre_gain_i,
  input  wire logic [sfe_pkg::GAIN_W-1:0]           post_gain_i,
  input  wire logic signed [sfe_pkg::SAMPLE_W-1:0]  left_i,
  input  wire logic signed [sfe_pkg::SAMPLE_W-1:0]  right_i,
  input  wire logic signed [sfe_pkg::TAP_W-1:0]     tap_i,
  input  wire logic [2*sfe_pkg::HIST_W-1:0]         hist_i,
  output logic [2*sfe_pkg::HIST_W-1:0]              hist_o,
  output sfe_pkg::mac_res_t                         res_o
);
  import sfe_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAP_COUNT);
  localparam int QW    = ACC_W - ACC_SHIFT;

  localparam logic signed [Y_W-1:0] Y_SAT_HI = 42'sd32767;
  localparam logic signed [Y_W-1:0] Y_SAT_LO = -42'sd32768;

  localparam logic [ACC_W-1:0]  ACC_BIAS  = {{(ACC_W-ACC_SHIFT){1'b0}}, {ACC_SHIFT{1'b1}}};
  localparam logic [PROD_W-1:0] POST_BIAS = {{(PROD_W-POST_SHIFT){1'b0}}, {POST_SHIFT{1'b1}}};
  localparam logic [PRE_W-1:0]  PRE_BIAS  = {{(PRE_W-PRE_SHIFT){1'b0}}, {PRE_SHIFT{1'b1}}};

  // returns {clip, saturated value}
  function automatic logic [SAMPLE_W:0] sat16(input logic signed [Y_W-1:0] v);
    logic [SAMPLE_W:0] r;
    if (v > Y_SAT_HI) begin
      r = {1'b1, Y_SAT_HI[SAMPLE_W-1:0]};
    end else if (v < Y_SAT_LO) begin
      r = {1'b1, Y_SAT_LO[SAMPLE_W-1:0]};
    end else begin
      r = {1'b0, v[SAMPLE_W-1:0]};
    end
    return r;
  endfunction

  logic signed [TAP_W-1:0]  mul_a;
  logic signed [HIST_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  mac_op_e                  op_q;

  logic signed [PRE_W-1:0]  pl_q, pr_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
  logic signed [QW-1:0]     ql_q, qr_q;
  logic signed [Y_W-1:0]    yl_q, yr_q;

  logic [ACC_W-1:0]         ql_sum, qr_sum;
  logic [PROD_W-1:0]        y_sum;
  logic [PRE_W-1:0]         bl_sum, br_sum;
  logic signed [Y_W-1:0]    vl, vr;
  logic [SAMPLE_W:0]        sl, sr;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.op)
      OP_PRE_L: begin
        mul_a = $signed({{(TAP_W-GAIN_W){1'b0}}, pre_gain_i});
        mul_b = HIST_W'(left_i);
      end
      OP_PRE_R: begin
        mul_a = $signed({{(TAP_W-GAIN_W){1'b0}}, pre_gain_i});
        mul_b = HIST_W'(right_i);
      end
      OP_TAP_L: begin
        mul_a = tap_i;
        mul_b = $signed(hist_i[HIST_W-1:0]);
      end
      OP_TAP_R: begin
        mul_a = tap_i;
        mul_b = $signed(hist_i[2*HIST_W-1:HIST_W]);
      end
      OP_POST_L: begin
        mul_a = $signed({{(TAP_W-GAIN_W){1'b0}}, post_gain_i});
        mul_b = HIST_W'(ql_q);
      end
      OP_POST_R: begin
        mul_a = $signed({{(TAP_W-GAIN_W){1'b0}}, post_gain_i});
        mul_b = HIST_W'(qr_q);
      end
      default: ;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // truncation toward zero: add 2^n-1 to negative values before the shift
  assign ql_sum = acc_l_q + (acc_l_q[ACC_W-1] ? ACC_BIAS : '0);
  assign qr_sum = acc_r_q + (acc_r_q[ACC_W-1] ? ACC_BIAS : '0);
  assign y_sum  = prod_q + (prod_q[PROD_W-1] ? POST_BIAS : '0);
  assign bl_sum = pl_q + (pl_q[PRE_W-1] ? PRE_BIAS : '0);
  assign br_sum = pr_q + (pr_q[PRE_W-1] ? PRE_BIAS : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else begin
      op_q <= ctl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (op_q)
      OP_PRE_L:  pl_q <= prod_q[PRE_W-1:0];
      OP_PRE_R:  pr_q <= prod_q[PRE_W-1:0];
      OP_POST_L: yl_q <= $signed(y_sum[PROD_W-1:POST_SHIFT]);
      OP_POST_R: yr_q <= $signed(y_sum[PROD_W-1:POST_SHIFT]);
      default: ;
    endcase
    if (ctl_i.acc_clr) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else begin
      if (op_q == OP_TAP_L) begin
        acc_l_q <= acc_l_q + ACC_W'(prod_q);
      end
      if (op_q == OP_TAP_R) begin
        acc_r_q <= acc_r_q + ACC_W'(prod_q);
      end
    end
    if (ctl_i.op == OP_QUANT) begin
      ql_q <= $signed(ql_sum[ACC_W-1:ACC_SHIFT]);
      qr_q <= $signed(qr_sum[ACC_W-1:ACC_SHIFT]);
    end
  end

  assign hist_o = {pr_q[HIST_W-1:0], pl_q[HIST_W-1:0]};

  always_comb begin
    if (filter_mode_i == MODE_FILTER) begin
      vl = yl_q;
      vr = yr_q;
    end else begin
      vl = Y_W'($signed(bl_sum[PRE_W-1:PRE_SHIFT]));
      vr = Y_W'($signed(br_sum[PRE_W-1:PRE_SHIFT]));
    end
    sl = sat16(vl);
    sr = sat16(vr);
    res_o.left    = $signed(sl[SAMPLE_W-1:0]);
    res_o.right   = $signed(sr[SAMPLE_W-1:0]);
    res_o.clipped = sl[SAMPLE_W] | sr[SAMPLE_W];
  end

endmodule

`default_nettype wire

// ===== src/stereo_fir_equalizer.sv =====
`default_nettype none

// Stereo FIR equalizer. Sample pairs are scaled by pre_gain (Q1.15); in bypass mode
// the result is returned directly, in filter mode it enters a TAP_COUNT-deep history
// and a FIR with one shared Q2.16 tap table runs over both channels, followed by
// post_gain (Q8.8) and 16-bit saturation with a clip flag. History and taps sit in
// two synchronous memories and a single 18x32 multiplier does all products, one
// product per cycle, two products per tap for a filter-mode pair. After reset a
// clearing pass zeroes both memories, during which in_stall_o stays high. Registers
// may be written only while idle.
module stereo_fir_equalizer #(
  parameter int TAP_COUNT = 128
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  action_i,
  input  wire logic signed [sfe_pkg::SAMPLE_W-1:0]   left_sample_i,
  input  wire logic signed [sfe_pkg::SAMPLE_W-1:0]   right_sample_i,
  input  wire logic [sfe_pkg::COEF_IDX_W-1:0]        coef_index_i,
  input  wire logic signed [sfe_pkg::TAP_W-1:0]      coef_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [sfe_pkg::SAMPLE_W-1:0]        left_out_o,
  output logic signed [sfe_pkg::SAMPLE_W-1:0]        right_out_o,
  output logic                                       clipped_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [sfe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [sfe_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import sfe_pkg::*;

  localparam int AW  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int KW0 = $clog2(TAP_COUNT + 1);
  localparam int KW  = (KW0 > 3) ? KW0 : 3;

  localparam logic [KW-1:0] K_LAST   = KW'(TAP_COUNT - 1);
  localparam logic [AW-1:0] ADDR_TOP = AW'(TAP_COUNT - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_HWR   = 3'd3;
  localparam logic [2:0] S_TAPS  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_POST  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [KW-1:0]            k_q, k_d;
  logic                     ph_q, ph_d;
  logic [AW-1:0]            newest_q, newest_d, rptr_q, rptr_d;
  logic [AW-1:0]            newest_nxt, rptr_prev;

  logic                     filter_mode_q;
  logic [GAIN_W-1:0]        pre_gain_q, post_gain_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;

  logic                     out_valid_q, out_load;
  logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;
  logic                     clipped_q;

  mac_ctl_t                 ctl;
  mac_res_t                 res;
  logic                     smp_load;
  logic                     coef_in_range;

  logic                     tap_we, hist_we, rd_en;
  logic [AW-1:0]            tap_waddr, hist_waddr;
  logic signed [TAP_W-1:0]  tap_wdata, tap_rdata;
  logic [2*HIST_W-1:0]      hist_wdata, hist_rdata, hist_new;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign coef_in_range = (32'(coef_index_i) < 32'(TAP_COUNT));
  assign newest_nxt    = (newest_q == ADDR_TOP) ? '0 : newest_q + 1'b1;
  assign rptr_prev     = (rptr_q == '0) ? ADDR_TOP : rptr_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    ph_d       = ph_q;
    newest_d   = newest_q;
    rptr_d     = rptr_q;
    ctl.op     = OP_NONE;
    ctl.acc_clr = 1'b0;
    tap_we     = 1'b0;
    tap_waddr  = k_q[AW-1:0];
    tap_wdata  = '0;
    hist_we    = 1'b0;
    hist_waddr = k_q[AW-1:0];
    hist_wdata = '0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    smp_load   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        tap_we  = 1'b1;
        hist_we = 1'b1;
        if (k_q == K_LAST) begin
          k_d     = '0;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_COEF) begin
            tap_we    = coef_in_range;
            tap_waddr = AW'(coef_index_i);
            tap_wdata = coef_value_i;
          end else begin
            smp_load = 1'b1;
            k_d      = '0;
            state_d  = S_PRE;
          end
        end
      end
      S_PRE: begin
        // each product is registered in prod_q, then in pl_q or pr_q; both are in place on exit
        if (k_q == KW'(0)) begin
          ctl.op = OP_PRE_L;
        end else if (k_q == KW'(1)) begin
          ctl.op = OP_PRE_R;
        end
        if (k_q == KW'(2)) begin
          state_d = (filter_mode_q == MODE_FILTER) ? S_HWR : S_OUT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_HWR: begin
        hist_we     = 1'b1;
        hist_waddr  = newest_nxt;
        hist_wdata  = hist_new;
        newest_d    = newest_nxt;
        rptr_d      = newest_nxt;
        ctl.acc_clr = 1'b1;
        k_d         = '0;
        ph_d        = 1'b0;
        state_d     = S_TAPS;
      end
      S_TAPS: begin
        // even cycle: fetch tap k, multiply right of tap k-1; odd: left of tap k
        if (!ph_q) begin
          rd_en = 1'b1;
          if (k_q != '0) begin
            ctl.op = OP_TAP_R;
          end
        end else begin
          ctl.op = OP_TAP_L;
          if (k_q == K_LAST) begin
            state_d = S_DRAIN;
          end else begin
            k_d    = k_q + 1'b1;
            rptr_d = rptr_prev;
          end
        end
        ph_d = !ph_q;
      end
      S_DRAIN: begin
        ctl.op  = OP_TAP_R;
        k_d     = '0;
        state_d = S_POST;
      end
      S_POST: begin
        if (k_q == KW'(1)) begin
          ctl.op = OP_QUANT;
        end else if (k_q == KW'(2)) begin
          ctl.op = OP_POST_L;
        end else if (k_q == KW'(3)) begin
          ctl.op = OP_POST_R;
        end
        if (k_q == KW'(4)) begin
          state_d = S_OUT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      k_q      <= '0;
      ph_q     <= 1'b0;
      newest_q <= '0;
      rptr_q   <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      ph_q     <= ph_d;
      newest_q <= newest_d;
      rptr_q   <= rptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= MODE_BYPASS;
      pre_gain_q    <= PRE_GAIN_RST;
      post_gain_q   <= POST_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FILTER_MODE: filter_mode_q <= cfg_data_i[0];
        REG_PRE_GAIN:    pre_gain_q    <= cfg_data_i;
        REG_POST_GAIN:   post_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_load) begin
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
    end
  end

  // output register: a transfer frees it, a finished item refills it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_out_q  <= res.left;
      right_out_q <= res.right;
      clipped_q   <= res.clipped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;
  assign clipped_o   = clipped_q;

  sfe_store #(
    .TAP_COUNT (TAP_COUNT),
    .AW        (AW)
  ) u_store (
    .clk_i        (clk_i),
    .tap_we_i     (tap_we),
    .tap_waddr_i  (tap_waddr),
    .tap_wdata_i  (tap_wdata),
    .hist_we_i    (hist_we),
    .hist_waddr_i (hist_waddr),
    .hist_wdata_i (hist_wdata),
    .rd_en_i      (rd_en),
    .tap_raddr_i  (k_q[AW-1:0]),
    .hist_raddr_i (rptr_q),
    .tap_rdata_o  (tap_rdata),
    .hist_rdata_o (hist_rdata)
  );

  sfe_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .filter_mode_i (filter_mode_q),
    .pre_gain_i    (pre_gain_q),
    .post_gain_i   (post_gain_q),
    .left_i        (left_q),
    .right_i       (right_q),
    .tap_i         (tap_rdata),
    .hist_i        (hist_rdata),
    .hist_o        (hist_new),
    .res_o         (res)
  );

  a_drain_after_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |-> $past(state_q == S_TAPS && ph_q && k_q == K_LAST))
    else $error("drain entered before the last tap");

  a_hist_write_filter_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_we && state_q != S_CLEAR) |-> filter_mode_q == MODE_FILTER)
    else $error("history written outside filter mode");

  a_coef_write_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == ACT_COEF) |=> state_q == S_IDLE)
    else $error("coefficient write started a computation");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result register loaded outside the output step");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import sfe_pkg::*;

  localparam int TAPS = 128;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic                       action;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic signed [TAP_W-1:0]    coef_value;
  } eq_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = ACT_SAMPLE;
  logic signed [SAMPLE_W-1:0] left_sample_i = '0;
  logic signed [SAMPLE_W-1:0] right_sample_i = '0;
  logic [COEF_IDX_W-1:0] coef_index_i = '0;
  logic signed [TAP_W-1:0] coef_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out_o;
  logic signed [SAMPLE_W-1:0] right_out_o;
  logic clipped_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  stereo_fir_equalizer #(.TAP_COUNT(TAPS)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // equalizer state as the block should hold it
  logic            mode_m = MODE_BYPASS;
  logic [15:0]     pre_gain_m = PRE_GAIN_RST;
  logic [15:0]     post_gain_m = POST_GAIN_RST;
  int              tap_m [TAPS] = '{default: 0};
  int              hist_l [TAPS] = '{default: 0};  // newest first
  int              hist_r [TAPS] = '{default: 0};

  eq_item_t        input_items [$];
  mac_res_t        predicted_pairs [$];
  eq_item_t        cur_item;
  int              send_gap = 0;
  int              stall_left = 0;
  int              hold_left = 0;
  int              hold_len = 0;
  int              hold_req = 0;
  int              hold_done = 0;
  logic            quiet = 1'b0;
  int              mismatches = 0;

  function automatic longint div_pow2(input longint v, input int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(input longint v, inout logic clip);
    if (v > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic equalize(input eq_item_t it);
    mac_res_t res;
    longint   sl, sr, pl, pr, acc_l, acc_r, yl, yr;
    logic     clip;
    int       k;
    if (it.action == ACT_COEF) begin
      tap_m[it.coef_index] = int'(it.coef_value);
      return;
    end
    clip = 1'b0;
    sl = longint'(it.left);
    sr = longint'(it.right);
    pl = sl * longint'(pre_gain_m);
    pr = sr * longint'(pre_gain_m);
    if (mode_m == MODE_BYPASS) begin
      yl = div_pow2(pl, PRE_SHIFT);
      yr = div_pow2(pr, PRE_SHIFT);
    end else begin
      for (k = TAPS - 1; k > 0; k--) begin
        hist_l[k] = hist_l[k-1];
        hist_r[k] = hist_r[k-1];
      end
      hist_l[0] = int'(pl);
      hist_r[0] = int'(pr);
      acc_l = 0;
      acc_r = 0;
      for (k = 0; k < TAPS; k++) begin
        acc_l += longint'(tap_m[k]) * longint'(hist_l[k]);
        acc_r += longint'(tap_m[k]) * longint'(hist_r[k]);
      end
      yl = div_pow2(div_pow2(acc_l, ACC_SHIFT) * longint'(post_gain_m), POST_SHIFT);
      yr = div_pow2(div_pow2(acc_r, ACC_SHIFT) * longint'(post_gain_m), POST_SHIFT);
    end
    res.left = clamp16(yl, clip);
    res.right = clamp16(yr, clip);
    res.clipped = clip;
    predicted_pairs.push_back(res);
  endtask

  // sender: one transfer per accepted item, random gaps while items wait
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) equalize(cur_item);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && input_items.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else if (input_items.size() != 0) begin
          cur_item = input_items.pop_front();
          in_valid_i <= 1'b1;
          action_i <= cur_item.action;
          left_sample_i <= cur_item.left;
          right_sample_i <= cur_item.right;
          coef_index_i <= cur_item.coef_index;
          coef_value_i <= cur_item.coef_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_req) begin
      hold_done <= hold_req;
      hold_left <= hold_len;
    end
  end

  // receiver: checks every result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    mac_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_pairs.size() == 0) begin
          $error("result with nothing predicted: left %0d right %0d clipped %0b",
                 left_out_o, right_out_o, clipped_o);
          mismatches++;
        end else begin
          want = predicted_pairs.pop_front();
          if (left_out_o !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out_o);
            mismatches++;
          end
          if (right_out_o !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out_o);
            mismatches++;
          end
          if (clipped_o !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, clipped_o);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_pair(input int l, input int r);
    eq_item_t it;
    it.action = ACT_SAMPLE;
    it.left = SAMPLE_W'(l);
    it.right = SAMPLE_W'(r);
    it.coef_index = COEF_IDX_W'($urandom);
    it.coef_value = TAP_W'($urandom);
    input_items.push_back(it);
  endtask

  task automatic add_tap(input int idx, input int val);
    eq_item_t it;
    it.action = ACT_COEF;
    it.left = SAMPLE_W'($urandom);
    it.right = SAMPLE_W'($urandom);
    it.coef_index = COEF_IDX_W'(idx);
    it.coef_value = TAP_W'(val);
    input_items.push_back(it);
  endtask

  function automatic eq_item_t random_item();
    eq_item_t it;
    it.action = ($urandom_range(0, 99) < 15) ? ACT_COEF : ACT_SAMPLE;
    it.left = SAMPLE_W'($urandom);
    it.right = SAMPLE_W'($urandom);
    it.coef_index = COEF_IDX_W'($urandom);
    it.coef_value = TAP_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.left = it.left >>> $urandom_range(0, 14);
      it.right = it.right >>> $urandom_range(0, 14);
    end
    // mostly modest taps so that filter sums stay near the output range
    if ($urandom_range(0, 4) != 0) it.coef_value = it.coef_value >>> $urandom_range(4, 12);
    return it;
  endfunction

  // idle point: no item queued or in transfer, every result back, pipeline settled
  task automatic drain();
    do @(negedge clk_i);
    while (input_items.size() != 0 || in_valid_i || predicted_pairs.size() != 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FILTER_MODE: mode_m = val[0];
      REG_PRE_GAIN:    pre_gain_m = val;
      REG_POST_GAIN:   post_gain_m = val;
      default: ;
    endcase
  endtask

  initial begin
    logic        mode;
    logic [15:0] pre, post;
    int          ph, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bypass at unity, taps loaded for later
    add_pair(32767, -32768);
    add_pair(-1, 1);
    add_pair(0, 0);
    add_tap(0, 65536);
    add_tap(127, -131072);
    add_tap(1, 131071);
    drain();
    // gain above unity clips, odd products truncate toward zero
    write_reg(REG_PRE_GAIN, 16'hffff);
    write_reg(REG_UNUSED, 16'h1234);
    add_pair(32767, -32768);
    add_pair(-3, 5);
    drain();
    write_reg(REG_PRE_GAIN, 16'd0);
    add_pair(-32768, 32767);
    drain();
    write_reg(REG_FILTER_MODE, 16'(MODE_FILTER));
    write_reg(REG_PRE_GAIN, PRE_GAIN_RST);
    add_pair(1000, -1000);
    add_pair(-7, 3);
    add_tap(1, 0);
    add_pair(123, -456);
    drain();
    write_reg(REG_POST_GAIN, 16'hffff);
    add_pair(32767, -32768);
    add_pair(-20000, 20000);
    drain();
    write_reg(REG_POST_GAIN, 16'd0);
    add_pair(100, -100);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) quiet = 1'b1;
      if (ph == 0) mode = MODE_BYPASS;
      else if (ph == 1) mode = MODE_FILTER;
      else mode = logic'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0:       pre = 16'd0;
        1:       pre = 16'hffff;
        2:       pre = PRE_GAIN_RST;
        default: pre = 16'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 4))
        0:       post = 16'd0;
        1:       post = 16'hffff;
        2:       post = POST_GAIN_RST;
        default: post = 16'($urandom_range(64, 1024));
      endcase
      write_reg(REG_FILTER_MODE, 16'(mode));
      write_reg(REG_PRE_GAIN, pre);
      write_reg(REG_POST_GAIN, post);
      // receiver holds off while the sender keeps offering items
      if (ph < 2) begin
        hold_len = (ph == 0) ? 300 : 1200;
        hold_req++;
      end
      for (n = 0; n < PHASE_ITEMS; n++) input_items.push_back(random_item());
      drain();
    end

    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && predicted_pairs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
